@@ hw/rtl/hcrd_pkg.sv @@
// Package for the HTML character reference decoder: word types, constants and name tables.
package hcrd_pkg;

  localparam int unsigned HoldDepth = 8;
  localparam int unsigned HoldIdxW  = $clog2(HoldDepth);
  localparam int unsigned HoldCntW  = $clog2(HoldDepth + 1);
  localparam int unsigned NumNames  = 17;
  localparam int unsigned DigitW    = 17;

  localparam logic [DigitW-1:0] DigitMax = '1;

  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharSemi  = 8'h3b;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharApos  = 8'h27;
  localparam logic [7:0] CharQuot  = 8'h22;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;

  typedef enum logic [5:0] {
    ModeIdle = 6'b000001,
    ModeAmp  = 6'b000010,
    ModeHash = 6'b000100,
    ModeDec  = 6'b001000,
    ModeHex  = 6'b010000,
    ModeName = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       run_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       from_reference;
    logic       run_end;
    logic       step_last;
  } out_word_t;

  // Results of one input word, sent in order: '&', held bytes, first tail, second tail.
  typedef struct packed {
    logic                amp;
    logic [HoldCntW-1:0] rep_cnt;
    logic                t0_v;
    logic [7:0]          t0_char;
    logic                t0_ref;
    logic                t1_v;
    logic [7:0]          t1_char;
    logic                run_last;
  } job_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [3:0] name_len(input int unsigned e);
    logic [3:0] n;
    unique case (e)
      0:           n = 4'd4;
      1, 2:        n = 4'd3;
      3, 4, 5, 6:  n = 4'd5;
      7:           n = 4'd4;
      10, 15:      n = 4'd7;
      default:     n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_at(input int unsigned e, input logic [2:0] pos);
    logic [63:0] s;
    logic [2:0]  k;
    unique case (e)
      0:       s = "amp;";
      1:       s = "lt;";
      2:       s = "gt;";
      3:       s = "quot;";
      4:       s = "apos;";
      5:       s = "nbsp;";
      6:       s = "copy;";
      7:       s = "reg;";
      8:       s = "mdash;";
      9:       s = "ndash;";
      10:      s = "hellip;";
      11:      s = "rsquo;";
      12:      s = "lsquo;";
      13:      s = "rdquo;";
      14:      s = "ldquo;";
      15:      s = "middot;";
      default: s = "trade;";
    endcase
    k = 3'(name_len(e) - 4'd1 - {1'b0, pos});
    return s[{k, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] name_result(input int unsigned e);
    logic [7:0] c;
    unique case (e)
      0:           c = CharAmp;
      1:           c = 8'h3c;
      2:           c = 8'h3e;
      3, 13, 14:   c = CharQuot;
      4, 11, 12:   c = CharApos;
      5:           c = CharSpace;
      6:           c = 8'h63;
      7:           c = 8'h72;
      8, 9:        c = CharDash;
      10, 15:      c = CharDot;
      default:     c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] map_value(input logic [DigitW-1:0] v, input logic sat);
    logic [7:0] c;
    c = CharSpace;
    if (sat) begin
      c = CharSpace;
    end else if (v >= DigitW'(1) && v <= DigitW'(255)) begin
      c = v[7:0];
    end else if (v == DigitW'(8216) || v == DigitW'(8217)) begin
      c = CharApos;
    end else if (v == DigitW'(8220) || v == DigitW'(8221)) begin
      c = CharQuot;
    end else if (v == DigitW'(8211) || v == DigitW'(8212)) begin
      c = CharDash;
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/hcrd_parser.sv @@
// Reference parser: parse state, held name bytes and the result list of each word.
module hcrd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  hcrd_pkg::in_word_t            word_i,
  output hcrd_pkg::job_t                job_o,
  input  logic [hcrd_pkg::HoldIdxW-1:0] rd_idx_i,
  output logic [7:0]                    rd_byte_o
);

  hcrd_pkg::mode_e                 mode_q, mode_d;
  logic [hcrd_pkg::HoldCntW-1:0]   held_cnt_q, held_cnt_d;
  logic [hcrd_pkg::DigitW-1:0]     dval_q, dval_d;
  logic                            sat_q, sat_d;
  logic [hcrd_pkg::NumNames-1:0]   cand_q, cand_d;
  logic [7:0]                      held_q [hcrd_pkg::HoldDepth];
  logic                            held_we;

  logic [7:0]                      b, lb;
  logic                            last;
  logic [hcrd_pkg::HoldCntW-1:0]   pos;
  logic [hcrd_pkg::NumNames-1:0]   cand, live;
  logic                            complete;
  logic [7:0]                      name_char;
  logic                            is_dec, is_hexl, digit_ok;
  logic [3:0]                      dig;
  logic [hcrd_pkg::DigitW+4:0]     prod, sum;
  logic                            ovf;
  logic [hcrd_pkg::DigitW-1:0]     new_val;
  logic                            new_sat;
  logic                            idle_to_amp;

  assign b    = word_i.in_byte;
  assign last = word_i.run_last;
  assign lb   = hcrd_pkg::to_lower(b);
  assign idle_to_amp = (b == hcrd_pkg::CharAmp) && !last;

  assign pos  = (mode_q == hcrd_pkg::ModeAmp) ? '0 : held_cnt_q;
  assign cand = (mode_q == hcrd_pkg::ModeAmp) ? '1 : cand_q;

  always_comb begin
    live      = '0;
    complete  = 1'b0;
    name_char = hcrd_pkg::CharSpace;
    for (int unsigned e = 0; e < hcrd_pkg::NumNames; e++) begin
      live[e] = cand[e] && (pos < hcrd_pkg::HoldCntW'(hcrd_pkg::name_len(e)))
                && (hcrd_pkg::name_at(e, pos[2:0]) == lb);
    end
    for (int e = hcrd_pkg::NumNames - 1; e >= 0; e--) begin
      if (live[e] && (hcrd_pkg::HoldCntW'(hcrd_pkg::name_len(e)) == pos + 1'b1)) begin
        complete  = 1'b1;
        name_char = hcrd_pkg::name_result(e);
      end
    end
  end

  assign is_dec   = (b >= 8'h30) && (b <= 8'h39);
  assign is_hexl  = (lb >= 8'h61) && (lb <= 8'h66);
  assign digit_ok = is_dec || ((mode_q == hcrd_pkg::ModeHex) && is_hexl);
  assign dig      = is_dec ? 4'(b - 8'h30) : 4'(lb - 8'h57);
  assign prod     = (mode_q == hcrd_pkg::ModeHex)
                    ? {1'b0, dval_q, 4'b0000}
                    : ({1'b0, dval_q, 4'b0000} - {3'b000, dval_q, 2'b00} -
                       {4'b0000, dval_q, 1'b0});
  assign sum      = prod + {{(hcrd_pkg::DigitW + 1){1'b0}}, dig};
  assign ovf      = sum > {5'b00000, hcrd_pkg::DigitMax};
  assign new_val  = ovf ? hcrd_pkg::DigitMax : sum[hcrd_pkg::DigitW-1:0];
  assign new_sat  = sat_q | ovf;

  always_comb begin
    logic do_clear;
    logic idle_slot0;
    logic idle_slot1;
    mode_d     = mode_q;
    held_cnt_d = held_cnt_q;
    dval_d     = dval_q;
    sat_d      = sat_q;
    cand_d     = cand_q;
    held_we    = 1'b0;
    job_o      = '0;
    job_o.run_last = last;
    do_clear   = 1'b0;
    idle_slot0 = 1'b0;
    idle_slot1 = 1'b0;
    unique case (mode_q)
      hcrd_pkg::ModeAmp, hcrd_pkg::ModeName: begin
        if (mode_q == hcrd_pkg::ModeAmp && b == hcrd_pkg::CharHash) begin
          mode_d = hcrd_pkg::ModeHash;
          if (last) begin
            job_o.t0_v    = 1'b1;
            job_o.t0_char = hcrd_pkg::map_value(dval_q, sat_q);
            job_o.t0_ref  = 1'b1;
            do_clear      = 1'b1;
          end
        end else if (live == '0) begin
          job_o.amp     = 1'b1;
          job_o.rep_cnt = pos;
          do_clear      = 1'b1;
          idle_slot0    = 1'b1;
        end else begin
          held_we    = 1'b1;
          held_cnt_d = pos + 1'b1;
          if (complete) begin
            job_o.t0_v    = 1'b1;
            job_o.t0_char = name_char;
            job_o.t0_ref  = 1'b1;
            do_clear      = 1'b1;
          end else if (last) begin
            job_o.amp     = 1'b1;
            job_o.rep_cnt = pos + 1'b1;
            do_clear      = 1'b1;
          end else begin
            mode_d = hcrd_pkg::ModeName;
            cand_d = live;
          end
        end
      end
      hcrd_pkg::ModeHash, hcrd_pkg::ModeDec, hcrd_pkg::ModeHex: begin
        if (mode_q == hcrd_pkg::ModeHash &&
            (b == hcrd_pkg::CharLowX || b == hcrd_pkg::CharUpX)) begin
          mode_d = hcrd_pkg::ModeHex;
          if (last) begin
            job_o.t0_v    = 1'b1;
            job_o.t0_char = hcrd_pkg::map_value(dval_q, sat_q);
            job_o.t0_ref  = 1'b1;
            do_clear      = 1'b1;
          end
        end else if (digit_ok) begin
          dval_d = new_val;
          sat_d  = new_sat;
          if (mode_q == hcrd_pkg::ModeHash) begin
            mode_d = hcrd_pkg::ModeDec;
          end
          if (last) begin
            job_o.t0_v    = 1'b1;
            job_o.t0_char = hcrd_pkg::map_value(new_val, new_sat);
            job_o.t0_ref  = 1'b1;
            do_clear      = 1'b1;
          end
        end else begin
          job_o.t0_v    = 1'b1;
          job_o.t0_char = hcrd_pkg::map_value(dval_q, sat_q);
          job_o.t0_ref  = 1'b1;
          do_clear      = 1'b1;
          idle_slot1    = (b != hcrd_pkg::CharSemi);
        end
      end
      default: begin
        do_clear   = 1'b1;
        idle_slot0 = 1'b1;
      end
    endcase
    if (do_clear) begin
      mode_d     = hcrd_pkg::ModeIdle;
      held_cnt_d = '0;
      dval_d     = '0;
      sat_d      = 1'b0;
      cand_d     = '1;
    end
    if (idle_slot0 || idle_slot1) begin
      if (idle_to_amp) begin
        mode_d = hcrd_pkg::ModeAmp;
      end else if (idle_slot0) begin
        job_o.t0_v    = 1'b1;
        job_o.t0_char = b;
        job_o.t0_ref  = 1'b0;
      end else begin
        job_o.t1_v    = 1'b1;
        job_o.t1_char = b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= hcrd_pkg::ModeIdle;
      held_cnt_q <= '0;
      dval_q     <= '0;
      sat_q      <= 1'b0;
      cand_q     <= '1;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      held_cnt_q <= held_cnt_d;
      dval_q     <= dval_d;
      sat_q      <= sat_d;
      cand_q     <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && held_we) begin
      held_q[pos[hcrd_pkg::HoldIdxW-1:0]] <= b;
    end
  end

  assign rd_byte_o = held_q[rd_idx_i];

  a_mode_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("Parse mode is not one-hot.");

  a_name_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != hcrd_pkg::ModeName) |-> (held_cnt_q == '0))
    else $error("Held count is nonzero outside a name.");

  a_digits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != hcrd_pkg::ModeDec && mode_q != hcrd_pkg::ModeHex) |->
    (dval_q == '0 && !sat_q))
    else $error("Digit accumulator is not clear outside a number.");

endmodule

@@ hw/rtl/html_char_reference_decoder.sv @@
// Top level of the HTML character reference decoder: parser, result sequencer, output register.
// Results of an accepted word go to the pending-result register, then through the output register.
// Throughput: one word per cycle while no word gives more than one result and the output is
// not stalled; else the input waits as the sequencer sends one result per unstalled cycle.
// Reset: rst_ni clears the parse state, the pending results and the output valid.
module html_char_reference_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hcrd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcrd_pkg::out_word_t out_word_o
);

  hcrd_pkg::job_t                  job_q, job_new, job_nxt;
  logic [hcrd_pkg::HoldCntW-1:0]   rep_idx_q, rep_idx_nxt;
  logic [7:0]                      rd_byte;
  logic                            job_busy, empty_after, move, accept;
  logic                            out_valid_q;
  hcrd_pkg::out_word_t             out_q, out_d;

  hcrd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .word_i    (in_word_i),
    .job_o     (job_new),
    .rd_idx_i  (rep_idx_q[hcrd_pkg::HoldIdxW-1:0]),
    .rd_byte_o (rd_byte)
  );

  assign job_busy = job_q.amp || (rep_idx_q < job_q.rep_cnt) || job_q.t0_v || job_q.t1_v;

  always_comb begin
    job_nxt     = job_q;
    rep_idx_nxt = rep_idx_q;
    out_d       = '0;
    priority if (job_q.amp) begin
      out_d.out_char = hcrd_pkg::CharAmp;
      job_nxt.amp    = 1'b0;
    end else if (rep_idx_q < job_q.rep_cnt) begin
      out_d.out_char = rd_byte;
      rep_idx_nxt    = rep_idx_q + 1'b1;
    end else if (job_q.t0_v) begin
      out_d.out_char       = job_q.t0_char;
      out_d.from_reference = job_q.t0_ref;
      job_nxt.t0_v         = 1'b0;
    end else begin
      out_d.out_char = job_q.t1_char;
      job_nxt.t1_v   = 1'b0;
    end
    empty_after = !(job_nxt.amp || (rep_idx_nxt < job_nxt.rep_cnt) ||
                    job_nxt.t0_v || job_nxt.t1_v);
    out_d.step_last = empty_after;
    out_d.run_end   = empty_after && job_q.run_last;
  end

  assign move       = job_busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = job_busy && !(move && empty_after);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q     <= '0;
      rep_idx_q <= '0;
    end else if (accept) begin
      job_q     <= job_new;
      rep_idx_q <= '0;
    end else if (move) begin
      job_q     <= job_nxt;
      rep_idx_q <= rep_idx_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idle_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_busy |-> !in_stall_o)
    else $error("Input stalled with no pending results.");

  a_run_end_is_step_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.run_end) |-> out_word_o.step_last)
    else $error("Run end flagged on a word that does not end its step.");

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_idx_q <= job_q.rep_cnt)
    else $error("Replay index ran past the held count.");

  a_accept_clears_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !job_new.amp && job_new.rep_cnt == '0 && !job_new.t0_v && !job_new.t1_v)
    |=> !job_busy)
    else $error("Pending results left after a word that gives none.");

endmodule

@@ tb/hcrd_checker.sv @@
`timescale 1ns / 100ps
// Checker for the HTML character reference decoder: predicts every output word and compares it.
module hcrd_checker
  import hcrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        err_count_o,
  output int        pending_o,
  output int        checked_o
);

  string ref_names [NumNames] = '{
    "amp;", "lt;", "gt;", "quot;", "apos;", "nbsp;", "copy;", "reg;", "mdash;", "ndash;",
    "hellip;", "rsquo;", "lsquo;", "rdquo;", "ldquo;", "middot;", "trade;"
  };
  logic [7:0] ref_chars [NumNames] = '{
    CharAmp, "<", ">", CharQuot, CharApos, CharSpace, "c", "r", CharDash, CharDash,
    CharDot, CharApos, CharApos, CharQuot, CharQuot, CharDot, "t"
  };

  mode_e               mode;
  logic [7:0]          held [HoldDepth];
  int unsigned         held_n;
  logic [DigitW-1:0]   acc;
  logic                acc_sat;
  logic [NumNames-1:0] live_names;
  out_word_t           expected_chars [$];
  int                  errs = 0;
  int                  checked = 0;

  function automatic void emit(input logic [7:0] c, input logic from_ref);
    out_word_t w;
    w.out_char       = c;
    w.from_reference = from_ref;
    w.run_end        = 1'b0;
    w.step_last      = 1'b0;
    expected_chars.push_back(w);
  endfunction

  function automatic void clear_ref();
    mode       = ModeIdle;
    held_n     = 0;
    acc        = '0;
    acc_sat    = 1'b0;
    live_names = '1;
  endfunction

  function automatic void resolve_number();
    logic [7:0] c;
    c = CharSpace;
    if (!acc_sat) begin
      case (acc)
        8211, 8212: c = CharDash;
        8216, 8217: c = CharApos;
        8220, 8221: c = CharQuot;
        default: begin
          if (acc != 0 && acc < 256) begin
            c = acc[7:0];
          end
        end
      endcase
    end
    emit(c, 1'b1);
    clear_ref();
  endfunction

  function automatic void idle_byte(input logic [7:0] b, input logic last);
    if (b != CharAmp) begin
      emit(b, 1'b0);
    end else if (last) begin
      emit(CharAmp, 1'b0);
    end else begin
      mode = ModeAmp;
    end
  endfunction

  function automatic void replay();
    emit(CharAmp, 1'b0);
    for (int i = 0; i < held_n; i++) begin
      emit(held[i], 1'b0);
    end
    clear_ref();
  endfunction

  function automatic void name_step(input logic [7:0] b, input logic last);
    logic [7:0]          lb;
    logic [NumNames-1:0] hit;
    int unsigned         pos;
    lb  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    pos = held_n;
    hit = '0;
    for (int e = 0; e < NumNames; e++) begin
      if (live_names[e] && pos < ref_names[e].len() && ref_names[e][pos] == lb) begin
        hit[e] = 1'b1;
      end
    end
    if (hit == '0) begin
      replay();
      idle_byte(b, last);
      return;
    end
    if (pos < HoldDepth) begin
      held[pos] = b;
      held_n    = pos + 1;
    end
    for (int e = 0; e < NumNames; e++) begin
      if (hit[e] && ref_names[e].len() == pos + 1) begin
        emit(ref_chars[e], 1'b1);
        clear_ref();
        return;
      end
    end
    if (last) begin
      replay();
      return;
    end
    live_names = hit;
  endfunction

  function automatic void decode_word(input in_word_t w);
    logic [7:0]  b;
    logic [7:0]  lb;
    logic        last;
    logic        hex;
    int          digit;
    int unsigned nv;
    int unsigned base;
    out_word_t   tail;
    b    = w.in_byte;
    lb   = w.in_byte | 8'h20;
    last = w.run_last;
    base = expected_chars.size();
    case (mode)
      ModeAmp: begin
        if (b == CharHash) begin
          mode = ModeHash;
          if (last) begin
            resolve_number();
          end
        end else begin
          mode       = ModeName;
          held_n     = 0;
          live_names = '1;
          name_step(b, last);
        end
      end
      ModeHash, ModeDec, ModeHex: begin
        hex = (mode == ModeHex);
        if (mode == ModeHash && (b == CharLowX || b == CharUpX)) begin
          mode = ModeHex;
          if (last) begin
            resolve_number();
          end
        end else begin
          mode  = hex ? ModeHex : ModeDec;
          digit = -1;
          if (b >= "0" && b <= "9") begin
            digit = int'(b - "0");
          end else if (hex && lb >= "a" && lb <= "f") begin
            digit = int'(lb - "a") + 10;
          end
          if (digit >= 0) begin
            nv = acc * (hex ? 16 : 10) + digit;
            if (nv > DigitMax) begin
              nv      = DigitMax;
              acc_sat = 1'b1;
            end
            acc = nv[DigitW-1:0];
            if (last) begin
              resolve_number();
            end
          end else begin
            resolve_number();
            if (b != CharSemi) begin
              idle_byte(b, last);
            end
          end
        end
      end
      ModeName: name_step(b, last);
      default: begin
        clear_ref();
        idle_byte(b, last);
      end
    endcase
    if (expected_chars.size() > base) begin
      tail           = expected_chars.pop_back();
      tail.step_last = 1'b1;
      tail.run_end   = last;
      expected_chars.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      clear_ref();
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output word: out_char %02h", out_word_i.out_char);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          checked++;
          if (out_word_i.out_char !== want.out_char) begin
            $error("out_char: expected %02h, actual %02h", want.out_char, out_word_i.out_char);
            errs++;
          end
          if (out_word_i.from_reference !== want.from_reference) begin
            $error("from_reference: expected %0b, actual %0b",
                   want.from_reference, out_word_i.from_reference);
            errs++;
          end
          if (out_word_i.run_end !== want.run_end) begin
            $error("run_end: expected %0b, actual %0b", want.run_end, out_word_i.run_end);
            errs++;
          end
          if (out_word_i.step_last !== want.step_last) begin
            $error("step_last: expected %0b, actual %0b", want.step_last, out_word_i.step_last);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_word(in_word_i);
      end
      pending_o <= expected_chars.size();
    end
    err_count_o <= errs;
    checked_o   <= checked;
  end

endmodule

@@ tb/tb_html_char_reference_decoder.sv @@
`timescale 1ns / 100ps
// Testbench top for the HTML character reference decoder: stimulus, pacing and final verdict.
module tb_html_char_reference_decoder;
  import hcrd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int WordTarget  = 360;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      calm = 1'b0;
  int        err_count;
  int        pending;
  int        checked;
  int        words_sent = 0;
  int        runs_sent = 0;
  int        cycles = 0;
  logic [7:0] run_bytes [$];

  string names [NumNames] = '{
    "amp;", "lt;", "gt;", "quot;", "apos;", "nbsp;", "copy;", "reg;", "mdash;", "ndash;",
    "hellip;", "rsquo;", "lsquo;", "rdquo;", "ldquo;", "middot;", "trade;"
  };
  int specials [6] = '{8211, 8212, 8216, 8217, 8220, 8221};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  html_char_reference_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  hcrd_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_word_i  (in_word),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_word_i (out_word),
    .err_count_o(err_count),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Cycle limit reached with %0d words still expected.", pending);
      $display("tb_html_char_reference_decoder: errors");
      $finish;
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      run_bytes.push_back(s[i]);
    end
  endfunction

  function automatic string shout(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++) begin
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) begin
        r[i] = r[i] - 8'd32;
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{in_byte: b, run_last: last};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic send_run();
    for (int i = 0; i < run_bytes.size(); i++) begin
      send_word(run_bytes[i], i == run_bytes.size() - 1);
    end
    if (run_bytes.size() != 0) begin
      runs_sent++;
    end
    run_bytes.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int          pick;
    int          pos;
    int unsigned v;
    string       txt;
    bit          drained_mid;
    drained_mid = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_bytes.push_back(8'h00);
    run_bytes.push_back(8'hff);
    send_run();
    add_text("&#x");
    send_run();
    add_text("&#;");
    send_run();
    add_text("&");
    send_run();
    add_text("&#999999");
    send_run();
    add_text("&AmP;&ndx");
    send_run();
    add_text("&hell");
    send_run();
    drain();

    while (words_sent < WordTarget) begin
      calm = (words_sent >= 150 && words_sent < 230);
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
          txt = shout(names[$urandom_range(0, NumNames - 1)]);
          if ($urandom_range(0, 9) == 0) begin
            txt = txt.substr(0, txt.len() - 2);
          end
          pos = run_bytes.size() + 1 + $urandom_range(0, txt.len() - 1);
          add_text("&");
          add_text(txt);
          if ($urandom_range(0, 9) == 0) begin
            run_bytes[pos] = 8'($urandom_range(0, 255));
          end
        end else if (pick < 12) begin
          case ($urandom_range(0, 4))
            0, 1:    v = $urandom_range(0, 255);
            2:       v = specials[$urandom_range(0, 5)];
            3:       v = $urandom_range(0, 140000);
            default: v = $urandom;
          endcase
          add_text("&#");
          if ($urandom_range(0, 1) == 1) begin
            add_text($urandom_range(0, 1) == 1 ? "x" : "X");
            txt = shout($sformatf("%0h", v));
          end else begin
            txt = $sformatf("%0d", v);
          end
          if ($urandom_range(0, 7) == 0) begin
            txt = {"00", txt};
          end
          if ($urandom_range(0, 11) == 0) begin
            txt = "";
          end
          add_text(txt);
          if ($urandom_range(0, 4) != 0) begin
            add_text(";");
          end
        end else if (pick < 14) begin
          run_bytes.push_back(CharAmp);
          run_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            run_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, run_bytes.size() - 1)) begin
          void'(run_bytes.pop_back());
        end
      end
      send_run();
      if (!drained_mid && words_sent >= 260) begin
        drained_mid = 1'b1;
        drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d words in %0d runs: named, decimal and hex references, bare, broken",
             words_sent, runs_sent);
    $display("and cut-off references, and raw bytes; %0d decoded words compared.", checked);
    if (err_count == 0) begin
      $display("tb_html_char_reference_decoder: clean");
    end else begin
      $display("tb_html_char_reference_decoder: errors");
    end
    $finish;
  end

endmodule

@@ html_char_reference_decoder.f @@
hw/rtl/hcrd_pkg.sv
hw/rtl/hcrd_parser.sv
hw/rtl/html_char_reference_decoder.sv
tb/hcrd_checker.sv
tb/tb_html_char_reference_decoder.sv
